/* hdl/sil_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sil_pkg
// Shared types and constants of the serial image loader: channel payloads,
// configuration register indexes, reset values, parse phases and header characters.
// ----------------------------------------------------------------------------
package sil_pkg;

  // default maximum length of a header field in digits
  localparam int unsigned MaxDigitsDefault = 8;

  // configuration register reset values
  localparam logic [31:0] RegionStartRst  = 32'h0008_0000;
  localparam logic [31:0] RegionEndRst    = 32'h0010_0000;
  localparam logic [31:0] FallbackBaseRst = 32'h0060_0000;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  typedef enum logic [CfgIdxW-1:0] {
    CfgRegionStart  = 2'd0,
    CfgRegionEnd    = 2'd1,
    CfgFallbackBase = 2'd2
  } cfg_idx_e;

  // parse phases
  localparam logic [1:0] PhAddr = 2'd0;
  localparam logic [1:0] PhSize = 2'd1;
  localparam logic [1:0] PhData = 2'd2;

  // header characters
  localparam logic [7:0] CharNewline = 8'h0A;
  localparam logic [7:0] CharZero    = 8'h30;
  localparam logic [7:0] CharNine    = 8'h39;
  localparam logic [7:0] CharLowerA  = 8'h61;
  localparam logic [7:0] CharLowerF  = 8'h66;
  localparam logic [7:0] CharUpperA  = 8'h41;
  localparam logic [7:0] CharUpperF  = 8'h46;

  // input transaction payload
  typedef struct packed {
    logic [7:0] rx_byte;
  } rx_item_t;

  // result transaction payload
  typedef struct packed {
    logic        echo_valid;
    logic [7:0]  echo_byte;
    logic        write_valid;
    logic [31:0] write_address;
    logic [7:0]  write_data;
    logic        jump_valid;
    logic [31:0] jump_address;
    logic        parse_error;
  } res_item_t;

endpackage

/* hdl/sil_stream_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sil_stream_if
// Valid/ready stream channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface sil_stream_if #(
  parameter type payload_t = logic [7:0]
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

/* hdl/sil_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sil_core
// Header parser, overlap check and image write sequencer. Computes the
// result of one received byte and advances the loader state on each
// accepted transaction.
// ----------------------------------------------------------------------------
module sil_core import sil_pkg::*; #(
  parameter int unsigned MaxDigits = MaxDigitsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               take_i,
  input  logic [7:0]         rx_byte_i,
  output res_item_t          res_o
);

  localparam logic [3:0] MaxCnt = 4'(MaxDigits);

  // configuration registers
  logic [31:0] region_start_q, region_end_q, fallback_base_q;

  // loader state
  logic [1:0]  phase_q, phase_d;
  logic [3:0]  digit_cnt_q, digit_cnt_d;
  logic [31:0] addr_acc_q, addr_acc_d;
  logic [26:0] size_acc_q, size_acc_d;
  logic [31:0] load_base_q, load_base_d;
  logic [31:0] wr_ptr_q, wr_ptr_d;
  logic [26:0] remain_q, remain_d;

  // character classification
  logic        is_nl, is_dec, is_hex;
  logic [3:0]  hex_val;
  logic [3:0]  cnt_inc;
  logic [26:0] size_next, size_fin;
  logic [32:0] end_addr;
  logic        start_in, end_in;
  logic [31:0] base_sel;
  logic [26:0] remain_dec;

  assign is_nl   = (rx_byte_i == CharNewline);
  assign is_dec  = (rx_byte_i >= CharZero) && (rx_byte_i <= CharNine);
  assign is_hex  = is_dec ||
                   ((rx_byte_i >= CharLowerA) && (rx_byte_i <= CharLowerF)) ||
                   ((rx_byte_i >= CharUpperA) && (rx_byte_i <= CharUpperF));
  assign hex_val = is_dec ? rx_byte_i[3:0] : rx_byte_i[3:0] + 4'd9;
  assign cnt_inc = digit_cnt_q + 4'd1;

  // size times ten plus the new decimal digit
  assign size_next = {size_acc_q[23:0], 3'b000} + {size_acc_q[25:0], 1'b0}
                   + {23'd0, rx_byte_i[3:0]};
  assign size_fin  = is_nl ? size_acc_q : size_next;

  // overlap check on start and unwrapped end address
  assign end_addr = {1'b0, addr_acc_q} + {6'd0, size_fin};
  assign start_in = (addr_acc_q >= region_start_q) && (addr_acc_q <= region_end_q);
  assign end_in   = (end_addr >= {1'b0, region_start_q}) &&
                    (end_addr <= {1'b0, region_end_q});
  assign base_sel = (start_in || end_in) ? fallback_base_q : addr_acc_q;

  assign remain_dec = remain_q - 27'd1;

  // next state and result of the current byte
  always_comb begin
    phase_d     = phase_q;
    digit_cnt_d = digit_cnt_q;
    addr_acc_d  = addr_acc_q;
    size_acc_d  = size_acc_q;
    load_base_d = load_base_q;
    wr_ptr_d    = wr_ptr_q;
    remain_d    = remain_q;
    res_o       = '0;

    unique case (phase_q)
      PhData: begin
        res_o.write_valid   = 1'b1;
        res_o.write_address = wr_ptr_q;
        res_o.write_data    = rx_byte_i;
        wr_ptr_d            = wr_ptr_q + 32'd1;
        remain_d            = remain_dec;
        if (remain_dec == '0) begin
          res_o.jump_valid   = 1'b1;
          res_o.jump_address = load_base_q;
          phase_d            = PhAddr;
          digit_cnt_d        = '0;
          addr_acc_d         = '0;
          size_acc_d         = '0;
        end
      end
      PhSize: begin
        res_o.echo_valid = 1'b1;
        res_o.echo_byte  = rx_byte_i;
        if (!is_nl && !is_dec) begin
          // bad character, restart the header
          res_o.parse_error = 1'b1;
          phase_d           = PhAddr;
          digit_cnt_d       = '0;
          addr_acc_d        = '0;
          size_acc_d        = '0;
        end else begin
          if (is_dec) begin
            size_acc_d  = size_next;
            digit_cnt_d = cnt_inc;
          end
          if (is_nl || (cnt_inc >= MaxCnt)) begin
            load_base_d = base_sel;
            wr_ptr_d    = base_sel;
            remain_d    = size_fin;
            if (size_fin == '0) begin
              // empty image jumps at once
              res_o.jump_valid   = 1'b1;
              res_o.jump_address = base_sel;
              phase_d            = PhAddr;
              digit_cnt_d        = '0;
              addr_acc_d         = '0;
              size_acc_d         = '0;
            end else begin
              phase_d     = PhData;
              digit_cnt_d = '0;
            end
          end
        end
      end
      default: begin
        // address phase, also the unused phase code
        res_o.echo_valid = 1'b1;
        res_o.echo_byte  = rx_byte_i;
        if (is_nl) begin
          phase_d     = PhSize;
          digit_cnt_d = '0;
          size_acc_d  = '0;
        end else if (!is_hex) begin
          res_o.parse_error = 1'b1;
          phase_d           = PhAddr;
          digit_cnt_d       = '0;
          addr_acc_d        = '0;
          size_acc_d        = '0;
        end else begin
          phase_d     = PhAddr;
          addr_acc_d  = {addr_acc_q[27:0], hex_val};
          digit_cnt_d = cnt_inc;
          if (cnt_inc >= MaxCnt) begin
            phase_d     = PhSize;
            digit_cnt_d = '0;
            size_acc_d  = '0;
          end
        end
      end
    endcase
  end

  // loader state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhAddr;
      digit_cnt_q <= '0;
      addr_acc_q  <= '0;
      size_acc_q  <= '0;
      load_base_q <= '0;
      wr_ptr_q    <= '0;
      remain_q    <= '0;
    end else if (take_i) begin
      phase_q     <= phase_d;
      digit_cnt_q <= digit_cnt_d;
      addr_acc_q  <= addr_acc_d;
      size_acc_q  <= size_acc_d;
      load_base_q <= load_base_d;
      wr_ptr_q    <= wr_ptr_d;
      remain_q    <= remain_d;
    end
  end

  // configuration register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      region_start_q  <= RegionStartRst;
      region_end_q    <= RegionEndRst;
      fallback_base_q <= FallbackBaseRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgRegionStart:  region_start_q  <= cfg_data_i;
        CfgRegionEnd:    region_end_q    <= cfg_data_i;
        CfgFallbackBase: fallback_base_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

endmodule

/* hdl/sil_out_reg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sil_out_reg
// Result register between the parser and the result channel. Frees its
// slot in the same cycle the held result is taken.
// ----------------------------------------------------------------------------
module sil_out_reg import sil_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      load_i,
  input  res_item_t res_i,
  input  logic      ready_i,
  output logic      free_o,
  output logic      valid_o,
  output res_item_t res_o
);

  logic      valid_q;
  res_item_t res_q;

  // slot can take a new result when empty or being drained
  assign free_o  = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign res_o   = res_q;

  // occupancy flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

endmodule

/* hdl/serial_image_loader_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_image_loader_unit
// Serial boot loader: parses a hex address and decimal size header, echoes
// it, streams the image bytes to memory writes and issues the jump.
// ----------------------------------------------------------------------------
// Every received byte produces exactly one result transaction in the cycle
// after it is accepted: the parser and overlap check sit in front of a single
// result register, so the block takes one byte per clock as long as the
// result channel drains, and its ready drops only while a result waits
// untaken. Configuration registers may be written at any time the loader is
// idle; there is no clearing pass after reset.
module serial_image_loader_unit import sil_pkg::*; #(
  parameter int unsigned MaxDigits = MaxDigitsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  sil_stream_if.sink         rx_chan,
  sil_stream_if.source       res_chan,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [31:0]        cfg_data_i
);

  logic      slot_free;
  logic      take;
  res_item_t core_res;

  assign rx_chan.ready = slot_free;
  assign take          = rx_chan.valid && slot_free;

  // parser and write sequencer
  sil_core #(
    .MaxDigits (MaxDigits)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .take_i     (take),
    .rx_byte_i  (rx_chan.payload.rx_byte),
    .res_o      (core_res)
  );

  // result register
  sil_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (take),
    .res_i   (core_res),
    .ready_i (res_chan.ready),
    .free_o  (slot_free),
    .valid_o (res_chan.valid),
    .res_o   (res_chan.payload)
  );

endmodule

/* hdl/sil_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sil_checker
// Port-level checks of the serial image loader, bound to the top level.
// ----------------------------------------------------------------------------
module sil_checker import sil_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      rx_valid_i,
  input logic      rx_ready_i,
  input rx_item_t  rx_payload_i,
  input logic      res_valid_i,
  input logic      res_ready_i,
  input res_item_t res_payload_i
);

  // a stalled result transaction holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_payload_i))
    else $error("stalled result changed");

  // each accepted byte shows up in the next result, echoed or written
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rx_valid_i && rx_ready_i |=> res_valid_i &&
      ((res_payload_i.echo_valid && res_payload_i.echo_byte == $past(rx_payload_i.rx_byte)) ||
       (res_payload_i.write_valid &&
        res_payload_i.write_data == $past(rx_payload_i.rx_byte))))
    else $error("accepted byte not reflected in result");

  // a byte is either header or image, never both
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> res_payload_i.echo_valid != res_payload_i.write_valid)
    else $error("result is both echo and write");

  // a parse error never comes with a jump or a write
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_payload_i.parse_error |->
      res_payload_i.echo_valid && !res_payload_i.jump_valid && !res_payload_i.write_valid)
    else $error("parse error with jump or write");

endmodule

bind serial_image_loader_unit sil_checker u_sil_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .rx_valid_i    (rx_chan.valid),
  .rx_ready_i    (rx_chan.ready),
  .rx_payload_i  (rx_chan.payload),
  .res_valid_i   (res_chan.valid),
  .res_ready_i   (res_chan.ready),
  .res_payload_i (res_chan.payload)
);
